// ===== sv/ddpc_pkg.sv =====
// ddpc_pkg: shared types, constants and tangent table for the differential drive pwm block
// depends on nothing; used by every module of the block by scoped names
`timescale 1ns / 1ps

package ddpc_pkg;

    localparam int QW        = 8;     // quotient bits (inner speed magnitude < 256)
    localparam int DIVW      = 18;    // divisor width: 131072 + tan up to 196608
    localparam int NUMW      = 26;    // numerator width: m * (131072 - tan)
    localparam logic [17:0] TWO_Q16 = 18'd131072;
    localparam logic [7:0]  SPEED_LIMIT = 8'd100;
    localparam logic [5:0]  MAX_ANGLE = 6'd45;
    localparam logic [23:0] RECIP_100 = 24'd10737419;  // ceil(2^30 / 100)

    localparam logic [3:0] REG_DIP = 4'd0;
    localparam logic [3:0] REG_PWM = 4'd1;

    // data handed from one divider cell to the next
    typedef struct packed {
        logic [NUMW-1:0] rem;     // running remainder, low bits still hold numerator
        logic [DIVW-1:0] div;     // divisor
        logic [QW-1:0]   quo;     // quotient bits so far
        logic            neg;     // outer speed negative
        logic            ang_pos; // angle above zero
        logic [8:0]      outer;   // signed outer speed, unclamped
        logic [15:0]     full;    // full scale duty
    } cell_t;

    // tangent of k degrees in unsigned q16
    function automatic logic [16:0] tan_q16(input logic [5:0] k);
        logic [16:0] t;
        case (k)
            6'd0: t = 17'd0;      6'd1: t = 17'd1144;   6'd2: t = 17'd2289;
            6'd3: t = 17'd3435;   6'd4: t = 17'd4583;   6'd5: t = 17'd5734;
            6'd6: t = 17'd6888;   6'd7: t = 17'd8047;   6'd8: t = 17'd9210;
            6'd9: t = 17'd10380;  6'd10: t = 17'd11556; 6'd11: t = 17'd12739;
            6'd12: t = 17'd13930; 6'd13: t = 17'd15130; 6'd14: t = 17'd16340;
            6'd15: t = 17'd17560; 6'd16: t = 17'd18792; 6'd17: t = 17'd20036;
            6'd18: t = 17'd21294; 6'd19: t = 17'd22566; 6'd20: t = 17'd23853;
            6'd21: t = 17'd25157; 6'd22: t = 17'd26478; 6'd23: t = 17'd27818;
            6'd24: t = 17'd29179; 6'd25: t = 17'd30560; 6'd26: t = 17'd31964;
            6'd27: t = 17'd33392; 6'd28: t = 17'd34846; 6'd29: t = 17'd36327;
            6'd30: t = 17'd37837; 6'd31: t = 17'd39378; 6'd32: t = 17'd40951;
            6'd33: t = 17'd42560; 6'd34: t = 17'd44205; 6'd35: t = 17'd45889;
            6'd36: t = 17'd47615; 6'd37: t = 17'd49385; 6'd38: t = 17'd51202;
            6'd39: t = 17'd53070; 6'd40: t = 17'd54991; 6'd41: t = 17'd56970;
            6'd42: t = 17'd59009; 6'd43: t = 17'd61113; 6'd44: t = 17'd63287;
            default: t = 17'd65536;
        endcase
        return t;
    endfunction

    // (d + 5) / 20 in q21, rounded up; period times this, shifted down 21, is the floor
    function automatic logic [21:0] scale_q21(input logic [3:0] d);
        logic [21:0] s;
        case (d)
            4'd0: s = 22'd524288;   4'd1: s = 22'd629146;   4'd2: s = 22'd734004;
            4'd3: s = 22'd838861;   4'd4: s = 22'd943719;   4'd5: s = 22'd1048576;
            4'd6: s = 22'd1153434;  4'd7: s = 22'd1258292;  4'd8: s = 22'd1363149;
            4'd9: s = 22'd1468007;  4'd10: s = 22'd1572864; 4'd11: s = 22'd1677722;
            4'd12: s = 22'd1782580; 4'd13: s = 22'd1887437; 4'd14: s = 22'd1992295;
            default: s = 22'd2097152;
        endcase
        return s;
    endfunction

endpackage

// ===== sv/ddpc_div_cell.sv =====
// ddpc_div_cell: one restoring-division step of the inner speed divider chain
// depends on ddpc_pkg
`timescale 1ns / 1ps

module ddpc_div_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            vld_in,
    input  ddpc_pkg::cell_t din,
    output logic            vld_out,
    output ddpc_pkg::cell_t dout
);

    localparam int NW = ddpc_pkg::NUMW;
    localparam int QW = ddpc_pkg::QW;
    localparam int DW = ddpc_pkg::DIVW;

    ddpc_pkg::cell_t  dat_next;
    ddpc_pkg::cell_t  dat_reg;
    logic             vld_reg;
    logic [NW-QW+1:0] hi;
    logic [NW-QW+1:0] diff;

    // compare the upper window with the divisor and shift in one quotient bit
    always_comb begin
        hi   = {1'b0, din.rem[NW-1:QW-1]};
        diff = hi - {{(NW-QW+2-DW){1'b0}}, din.div};
        dat_next = din;
        if (!diff[NW-QW+1]) begin
            dat_next.rem = {diff[DW-1:0], din.rem[QW-2:0], 1'b0};
            dat_next.quo = {din.quo[QW-2:0], 1'b1};
        end else begin
            dat_next.rem = {din.rem[NW-2:0], 1'b0};
            dat_next.quo = {din.quo[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dat_reg <= dat_next;
        end
    end

    assign vld_out = vld_reg;
    assign dout    = dat_reg;

endmodule

// ===== sv/ddpc_drive.sv =====
// ddpc_drive: wheel clamp, duty scaling and result register
// depends on ddpc_pkg
`timescale 1ns / 1ps

module ddpc_drive (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            vld_in,
    input  ddpc_pkg::cell_t din,
    output logic            vld_out,
    output logic [15:0]     left_duty,
    output logic            left_reverse,
    output logic [15:0]     right_duty,
    output logic            right_reverse
);

    logic signed [8:0] inner;
    logic signed [8:0] lw;
    logic signed [8:0] rw;
    logic [6:0]        lmag;
    logic [6:0]        rmag;
    logic [22:0]       lprod_next;
    logic [22:0]       rprod_next;
    logic              vld1_reg;
    logic [22:0]       lprod_reg;
    logic [22:0]       rprod_reg;
    logic              lr1_reg;
    logic              rr1_reg;
    logic [46:0]       lquo;
    logic [46:0]       rquo;
    logic [15:0]       ld_next;
    logic [15:0]       rd_next;
    logic              vld_reg;
    logic [15:0]       ld_reg;
    logic [15:0]       rd_reg;
    logic              lr_reg;
    logic              rr_reg;

    function automatic logic [6:0] clamp_mag(input logic signed [8:0] v);
        logic [8:0] a;
        a = v[8] ? 9'(-v) : 9'(v);
        return (a > 9'd100) ? 7'd100 : a[6:0];
    endfunction

    // restore sign, pick which wheel is slowed, scale by wheel magnitude
    always_comb begin
        inner = din.neg ? -$signed({1'b0, din.quo}) : $signed({1'b0, din.quo});
        lw    = din.ang_pos ? $signed(din.outer) : inner;
        rw    = din.ang_pos ? inner : $signed(din.outer);
        lmag  = clamp_mag(lw);
        rmag  = clamp_mag(rw);
        lprod_next = din.full * lmag;
        rprod_next = din.full * rmag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lprod_reg <= lprod_next;
            rprod_reg <= rprod_next;
            lr1_reg   <= lw[8];
            rr1_reg   <= rw[8];
        end
    end

    // divide by 100 through reciprocal multiply, exact for products below 2^23
    always_comb begin
        lquo    = lprod_reg * ddpc_pkg::RECIP_100;
        rquo    = rprod_reg * ddpc_pkg::RECIP_100;
        ld_next = lquo[45:30];
        rd_next = rquo[45:30];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ld_reg <= ld_next;
            rd_reg <= rd_next;
            lr_reg <= lr1_reg;
            rr_reg <= rr1_reg;
        end
    end

    assign vld_out       = vld_reg;
    assign left_duty     = ld_reg;
    assign right_duty    = rd_reg;
    assign left_reverse  = lr_reg;
    assign right_reverse = rr_reg;

endmodule

// ===== sv/differential_drive_pwm_command.sv =====
// differential_drive_pwm_command: top level, front end, divider chain and output stage
// depends on ddpc_pkg, ddpc_div_cell, ddpc_drive
`timescale 1ns / 1ps

// Turns a steering angle and an outer wheel speed into left and right pwm compare values
// with reverse bits. One command is taken every cycle while the result side is not
// stalled. There are eleven register stages: one front-end stage (tangent lookup,
// multiply, full scale), a chain of eight divider cells that each produce one bit of the
// inner speed, and two output stages (wheel scale, divide by 100). The whole pipeline
// advances together and holds when the result side stalls with a result waiting.
// Registers: index 0 dip switch scale, index 1 timer period.

module differential_drive_pwm_command (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // [7:0] steer_angle, [15:8] outer_speed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,      // [15:0] left_duty, [16] left_reverse,
                                      // [32:17] right_duty, [33] right_reverse, [39:34] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int NC = ddpc_pkg::QW;

    logic [3:0]        dip_reg;
    logic [15:0]       pwm_reg;
    logic              en;
    logic signed [7:0] ang;
    logic signed [7:0] spd;
    logic [7:0]        amag;
    logic [5:0]        aidx;
    logic [16:0]       tan;
    logic [7:0]        m;
    logic [15:0]       period;
    logic [21:0]       fscale;
    logic [37:0]       fprod;
    ddpc_pkg::cell_t   front_next;
    ddpc_pkg::cell_t   front_reg;
    logic              front_vld_reg;
    ddpc_pkg::cell_t   chain [NC+1];
    logic              cvld [NC+1];
    logic [15:0]       ld;
    logic [15:0]       rd;
    logic              lr;
    logic              rr;

    // configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dip_reg <= 4'd0;
            pwm_reg <= 16'hFFFF;
        end else if (cfg_valid) begin
            case (cfg_index)
                ddpc_pkg::REG_DIP: dip_reg <= cfg_data[3:0];
                ddpc_pkg::REG_PWM: pwm_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline moves whenever the output slot is free or being taken
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // front end: tangent, numerator, divisor and full scale
    always_comb begin
        ang    = $signed(s_tdata[7:0]);
        spd    = $signed(s_tdata[15:8]);
        amag   = ang[7] ? 8'(-ang) : 8'(ang);
        aidx   = (amag > 8'(ddpc_pkg::MAX_ANGLE)) ? ddpc_pkg::MAX_ANGLE : amag[5:0];
        tan    = ddpc_pkg::tan_q16(aidx);
        if (spd > $signed(ddpc_pkg::SPEED_LIMIT)) m = ddpc_pkg::SPEED_LIMIT;
        else m = spd[7] ? 8'(-spd) : 8'(spd);
        period = (pwm_reg != 16'd0) ? pwm_reg - 16'd1 : 16'd0;
        fscale = ddpc_pkg::scale_q21(dip_reg);
        fprod  = period * fscale;
        front_next.rem     = m * (ddpc_pkg::TWO_Q16 - {1'b0, tan});
        front_next.div     = ddpc_pkg::TWO_Q16 + {1'b0, tan};
        front_next.quo     = '0;
        front_next.neg     = spd[7];
        front_next.ang_pos = !ang[7] && (ang != 8'sd0);
        front_next.outer   = {spd[7], spd};
        front_next.full    = fprod[36:21];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_vld_reg <= 1'b0;
        end else if (en) begin
            front_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            front_reg <= front_next;
        end
    end

    assign chain[0] = front_reg;
    assign cvld[0]  = front_vld_reg;

    // divider chain, one quotient bit per cell
    for (genvar i = 0; i < NC; i++) begin : g_cell
        ddpc_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .vld_in  (cvld[i]),
            .din     (chain[i]),
            .vld_out (cvld[i+1]),
            .dout    (chain[i+1])
        );
    end

    ddpc_drive u_drive (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .vld_in        (cvld[NC]),
        .din           (chain[NC]),
        .vld_out       (m_tvalid),
        .left_duty     (ld),
        .left_reverse  (lr),
        .right_duty    (rd),
        .right_reverse (rr)
    );

    assign m_tdata = {6'd0, rr, rd, lr, ld};

    // checks
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready) else $error("input stalled with empty output");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_stall_prop: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(front_reg) && $stable(front_vld_reg))
        else $error("front stage moved during stall");

endmodule
